// ===== rtl/sspq_pkg.sv =====
// Shared types and constants of the stable sorted priority queue.
`default_nettype none

package sspq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned PrioW   = 16;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_POPPED    = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input transaction
    logic execute;  // update the store and the result register
  } sspq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sspq_ctrl.sv =====
// Controller of the priority queue: sequences capture, execute and result handoff.
`default_nettype none

module sspq_ctrl
  import sspq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output sspq_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // Take a new transaction only when the result register is free by the next edge.
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        out_valid_d   = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sspq_datapath.sv =====
// Datapath of the priority queue: sorted register array, count and result register.
`default_nettype none

module sspq_datapath
  import sspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sspq_cmd_t        cmd_i,
  input  wire logic             op_i,
  input  wire logic [DataW-1:0] data_value_i,
  input  wire logic [PrioW-1:0] priority_req_i,
  output logic [StatusW-1:0]    status_o,
  output logic [DataW-1:0]      popped_data_o,
  output logic [PrioW-1:0]      popped_priority_o,
  output logic [CountW-1:0]     entry_count_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [DataW-1:0]   op_data_q;
  logic [PrioW-1:0]   op_prio_q;
  logic               op_q;

  logic [DataW-1:0]   data_q [QUEUE_DEPTH];
  logic [PrioW-1:0]   prio_q [QUEUE_DEPTH];
  logic [DataW-1:0]   data_d [QUEUE_DEPTH];
  logic [PrioW-1:0]   prio_d [QUEUE_DEPTH];
  logic [CntW-1:0]    count_q, count_d;

  logic [QUEUE_DEPTH-1:0] behind;  // slot holds nothing or a higher priority value
  logic                   is_full, is_empty, do_insert, do_pop;

  status_e            status_d;
  logic [StatusW-1:0] status_q;
  logic [DataW-1:0]   pdata_d, pdata_q;
  logic [PrioW-1:0]   pprio_d, pprio_q;
  logic [CntW+CountW-1:0] count_wide;

  assign is_full   = (count_q == CntW'(QUEUE_DEPTH));
  assign is_empty  = (count_q == '0);
  assign do_insert = (op_e'(op_q) == OP_INSERT) && !is_full;
  assign do_pop    = (op_e'(op_q) == OP_POP) && !is_empty;

  // Sorted order makes behind a thermometer code; the insert point is its first set bit.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    assign behind[i] = (CntW'(i) >= count_q) || (prio_q[i] > op_prio_q);

    always_comb begin
      data_d[i] = data_q[i];
      prio_d[i] = prio_q[i];
      if (do_insert && behind[i]) begin
        if (i == 0) begin
          data_d[i] = op_data_q;
          prio_d[i] = op_prio_q;
        end else if (behind[(i == 0) ? 0 : i-1]) begin
          data_d[i] = data_q[(i == 0) ? 0 : i-1];
          prio_d[i] = prio_q[(i == 0) ? 0 : i-1];
        end else begin
          data_d[i] = op_data_q;
          prio_d[i] = op_prio_q;
        end
      end else if (do_pop && (i < QUEUE_DEPTH - 1)) begin
        data_d[i] = data_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        prio_d[i] = prio_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.execute) begin
        data_q[i] <= data_d[i];
        prio_q[i] <= prio_d[i];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    pdata_d  = '0;
    pprio_d  = '0;
    status_d = STAT_INSERTED;
    if (op_e'(op_q) == OP_INSERT) begin
      if (is_full) begin
        status_d = STAT_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = STAT_UNDERFLOW;
      end else begin
        status_d = STAT_POPPED;
        pdata_d  = data_q[0];
        pprio_d  = prio_q[0];
        count_d  = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      op_data_q <= data_value_i;
      op_prio_q <= priority_req_i;
    end
    if (cmd_i.execute) begin
      status_q <= status_d;
      pdata_q  <= pdata_d;
      pprio_q  <= pprio_d;
    end
  end

  // Count as seen after the item, held by count_q once execute has passed.
  assign count_wide        = {{CountW{1'b0}}, count_q};
  assign status_o          = status_q;
  assign popped_data_o     = pdata_q;
  assign popped_priority_o = pprio_q;
  assign entry_count_o     = count_wide[CountW-1:0];

endmodule

`default_nettype wire

// ===== rtl/stable_sorted_priority_queue.sv =====
// Stable sorted priority queue: top level with stream ports.
//
// Each input transaction carries an operation in s_axis_tuser (0 insert,
// 1 pop) and an entry in s_axis_tdata (data word and priority). Every input
// transaction yields exactly one output transaction with a status in
// m_axis_tuser and the popped entry plus the entry count in m_axis_tdata.
// Entries are held lowest priority value first; equal priorities leave in
// arrival order. Insert into a full queue is dropped (status 3), pop on an
// empty queue reports underflow (status 2).
// Each accepted input is first captured, then the execute step of the
// controller updates the sorted register array and the result register;
// no new item is taken until that execute step has been done.
// Reset empties the queue and drops any pending result. While the receiver
// stalls, the result is held and new items are refused until the
// result has been taken or is taken in the same cycle.
`default_nettype none

module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [31:0] data_value, [47:32] priority_req
  input  wire logic        s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [31:0] popped_data, [47:32] popped_priority,
                                           // [52:48] entry_count, [55:53] zero
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  sspq_cmd_t          cmd;
  logic [DataW-1:0]   popped_data;
  logic [PrioW-1:0]   popped_priority;
  logic [CountW-1:0]  entry_count;

  sspq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sspq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .op_i              (s_axis_tuser),
    .data_value_i      (s_axis_tdata[31:0]),
    .priority_req_i    (s_axis_tdata[47:32]),
    .status_o          (m_axis_tuser),
    .popped_data_o     (popped_data),
    .popped_priority_o (popped_priority),
    .entry_count_o     (entry_count)
  );

  assign m_axis_tdata = {3'b000, entry_count, popped_priority, popped_data};

endmodule

`default_nettype wire
